/* src/elx_pkg.sv */
// Package for the expression lexer: constants, token kinds, special codes, error codes and word types.
// No dependencies.
`timescale 1ns / 1ps
package elx_pkg;
    localparam int MaxNameLen = 16;
    localparam int MaxNames   = 64;
    localparam int NameBits   = $clog2(MaxNameLen + 2);
    localparam int PosBits    = $clog2(MaxNameLen);
    localparam int IdBits     = $clog2(MaxNames);
    localparam int CountBits  = $clog2(MaxNames + 1);
    localparam int TabDepth   = MaxNames * MaxNameLen;
    localparam int TabBits    = $clog2(TabDepth);

    localparam logic [1:0] KIND_SPEC  = 2'd0;
    localparam logic [1:0] KIND_CONST = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_FULL     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic [2:0] SPEC_ADD = 3'd0;
    localparam logic [2:0] SPEC_SUB = 3'd1;
    localparam logic [2:0] SPEC_MUL = 3'd2;
    localparam logic [2:0] SPEC_DIV = 3'd3;
    localparam logic [2:0] SPEC_LP  = 3'd4;
    localparam logic [2:0] SPEC_RP  = 3'd5;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [2:0]  spec_code;
        logic [31:0] token_value;
        logic [7:0]  digit_count;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_tok;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_chr;
endpackage

/* src/elx_if.sv */
// Valid/ready channel interfaces for characters and tokens.
// Depends on elx_pkg.
`timescale 1ns / 1ps
interface elx_chr_if;
    logic           valid;
    logic           ready;
    elx_pkg::t_chr  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface elx_tok_if;
    logic           valid;
    logic           ready;
    elx_pkg::t_tok  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/elx_lookup.sv */
// Name table search and insert engine, holding the character and length memories.
// Depends on elx_pkg.
`timescale 1ns / 1ps
module elx_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [elx_pkg::NameBits-1:0]  i_len,
    input  logic [7:0]                    i_name [elx_pkg::MaxNameLen],
    output logic                          o_done,
    output logic [31:0]                   o_value,
    output logic [1:0]                    o_err
);
    typedef enum logic [2:0] {S_IDLE, S_LEN, S_CHR, S_CMP, S_WR, S_FIN} t_st;

    t_st                              r_st;
    logic [elx_pkg::CountBits-1:0]    r_count;
    logic [elx_pkg::CountBits-1:0]    r_idx;
    logic [elx_pkg::NameBits-1:0]     r_pos;
    logic                             r_done;
    logic [31:0]                      r_value;
    logic [1:0]                       r_err;
    logic [4:0]                       r_len_q;
    logic [7:0]                       r_chr_q;
    logic [4:0]                       m_len [elx_pkg::MaxNames];
    logic [7:0]                       m_chr [elx_pkg::TabDepth];
    logic [elx_pkg::IdBits-1:0]       w_id;
    logic [elx_pkg::PosBits-1:0]      w_pos;
    logic [elx_pkg::TabBits-1:0]      w_addr;
    logic                             w_we;

    assign w_id   = r_idx[elx_pkg::IdBits-1:0];
    assign w_pos  = r_pos[elx_pkg::PosBits-1:0];
    assign w_addr = {w_id, w_pos};
    assign w_we   = (r_st == S_WR) &&
                    (r_count != elx_pkg::CountBits'(elx_pkg::MaxNames));

    always_ff @(posedge i_clk) begin
        r_len_q <= m_len[w_id];
        r_chr_q <= m_chr[w_addr];
        if (w_we) begin
            m_chr[w_addr] <= i_name[w_pos];
            if (r_pos == i_len - 1'b1) begin
                m_len[w_id] <= 5'(i_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx <= '0;
                        r_pos <= '0;
                        if (i_len > elx_pkg::NameBits'(elx_pkg::MaxNameLen)) begin
                            r_value <= '0;
                            r_err   <= elx_pkg::ERR_TOO_LONG;
                            r_st    <= S_FIN;
                        end else if (r_count == 0) begin
                            r_st <= S_WR;
                        end else begin
                            r_st <= S_LEN;
                        end
                    end
                end
                S_LEN: r_st <= S_CHR;
                S_CHR: begin
                    if (r_len_q != 5'(i_len)) begin
                        r_pos <= '0;
                        if (r_idx + 1'b1 == r_count) begin
                            r_idx <= r_count;
                            r_st  <= S_WR;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= S_LEN;
                        end
                    end else begin
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_chr_q != i_name[w_pos]) begin
                        r_pos <= '0;
                        if (r_idx + 1'b1 == r_count) begin
                            r_idx <= r_count;
                            r_st  <= S_WR;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= S_LEN;
                        end
                    end else if (r_pos == i_len - 1'b1) begin
                        r_value <= 32'(r_idx);
                        r_err   <= elx_pkg::ERR_OK;
                        r_st    <= S_FIN;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        r_st  <= S_CHR;
                    end
                end
                S_WR: begin
                    if (r_count == elx_pkg::CountBits'(elx_pkg::MaxNames)) begin
                        r_value <= '0;
                        r_err   <= elx_pkg::ERR_FULL;
                        r_st    <= S_FIN;
                    end else if (r_pos == i_len - 1'b1) begin
                        r_value <= 32'(r_count);
                        r_err   <= elx_pkg::ERR_OK;
                        r_count <= r_count + 1'b1;
                        r_st    <= S_FIN;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_FIN: begin
                    r_done <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_err   = r_err;
endmodule

/* src/expression_lexer_with_ident_table_top.sv */
// Top level of the expression lexer: character scanner, constant accumulator, token output.
// Depends on elx_pkg, elx_if and elx_lookup.
//   channel  dir  word
//   i_chr    in   char_in, end_of_text
//   o_tok    out  token fields, last_of_run
// The scanner takes a new byte only after the tokens of the last one are sent.
// A finished identifier also waits for the table search, which checks the stored names one
// after another through the single read port of the name memory and inserts a new name at
// one byte per cycle. Reset is synchronous and clears the table count.
// Tokens wait in a two-entry result buffer; the scanner stalls until every token in it is taken.
`timescale 1ns / 1ps
module expression_lexer_with_ident_table_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    elx_chr_if.sink  i_chr,
    elx_tok_if.source o_tok
);
    typedef enum logic [2:0] {S_IN, S_ID1, S_ID2, S_REST, S_OUT0, S_OUT1} t_st;

    t_st            r_st;
    logic [1:0]     r_mode;
    logic [31:0]    r_acc;
    logic [7:0]     r_digits;
    logic           r_ovf;
    logic [7:0]     r_name [elx_pkg::MaxNameLen];
    logic [elx_pkg::NameBits-1:0] r_nlen;
    logic [7:0]     r_c;
    logic           r_eot;
    logic           r_start;
    elx_pkg::t_tok  r_res [2];
    logic [1:0]     r_n;
    logic           w_done;
    logic [31:0]    w_val;
    logic [1:0]     w_err;
    logic           w_dig, w_alp, w_spec;
    logic [2:0]     w_code;
    logic [3:0]     w_d;
    logic [35:0]    w_prod;
    elx_pkg::t_tok  w_ident;

    localparam logic [1:0] M_IDLE = 2'd0, M_CONST = 2'd1, M_IDENT = 2'd2;

    elx_lookup u_lookup (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_len(r_nlen),
        .i_name(r_name), .o_done(w_done), .o_value(w_val), .o_err(w_err)
    );

    assign w_dig = (r_c >= 8'h30) && (r_c <= 8'h39);
    assign w_alp = ((r_c >= 8'h61) && (r_c <= 8'h7a)) || ((r_c >= 8'h41) && (r_c <= 8'h5a));
    assign w_d   = r_c[3:0];
    assign w_prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 36'(w_d);

    always_comb begin
        w_spec = 1'b1;
        case (r_c)
            8'h2b: w_code = elx_pkg::SPEC_ADD;
            8'h2d: w_code = elx_pkg::SPEC_SUB;
            8'h2a: w_code = elx_pkg::SPEC_MUL;
            8'h2f: w_code = elx_pkg::SPEC_DIV;
            8'h28: w_code = elx_pkg::SPEC_LP;
            8'h29: w_code = elx_pkg::SPEC_RP;
            default: begin
                w_code = elx_pkg::SPEC_ADD;
                w_spec = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ident = '0;
        w_ident.token_kind  = elx_pkg::KIND_IDENT;
        w_ident.token_value = w_val;
        w_ident.error_code  = w_err;
    end

    // Shared constant-token builder; the second stage applies the byte after any constant or identifier flush.
    function automatic elx_pkg::t_tok f_const(input logic [31:0] acc, input logic [7:0] dg,
                                              input logic ovf);
        elx_pkg::t_tok t;
        t = '0;
        t.token_kind  = elx_pkg::KIND_CONST;
        t.token_value = acc;
        t.digit_count = dg;
        t.error_code  = ovf ? elx_pkg::ERR_OVERFLOW : elx_pkg::ERR_OK;
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IN;
            r_mode  <= M_IDLE;
            r_nlen  <= '0;
            r_start <= 1'b0;
            r_n     <= '0;
        end else begin
            r_start <= 1'b0;
            case (r_st)
                S_IN: begin
                    if (i_chr.valid) begin
                        r_c   <= i_chr.data.char_in;
                        r_eot <= i_chr.data.end_of_text;
                        r_n   <= '0;
                        r_st  <= S_ID1;
                    end
                end
                S_ID1: begin
                    if (r_mode == M_CONST && !w_dig) begin
                        r_res[0] <= f_const(r_acc, r_digits, r_ovf);
                        r_n      <= 2'd1;
                        r_mode   <= M_IDLE;
                        r_st     <= S_REST;
                    end else if (r_mode == M_IDENT && !w_dig && !w_alp) begin
                        r_start <= 1'b1;
                        r_mode  <= M_IDLE;
                        r_st    <= S_ID2;
                    end else begin
                        r_st <= S_REST;
                    end
                end
                S_ID2: begin
                    if (w_done) begin
                        r_res[r_n[0]] <= w_ident;
                        r_n           <= r_n + 1'b1;
                        if (r_eot && r_mode != M_IDLE) begin
                            r_mode <= M_IDLE;
                            r_st   <= S_OUT0;
                        end else begin
                            r_st <= (r_n == 2'd0) ? S_REST : S_OUT0;
                        end
                    end
                end
                S_REST: begin
                    r_st <= S_OUT0;
                    if (r_mode == M_CONST) begin
                        if (w_prod[35:32] != 4'd0) begin
                            r_acc <= '1;
                            r_ovf <= 1'b1;
                        end else begin
                            r_acc <= w_prod[31:0];
                        end
                        if (r_digits != 8'hff) r_digits <= r_digits + 1'b1;
                        if (r_eot) begin
                            r_res[r_n[0]] <= f_const(w_prod[35:32] != 4'd0 ? '1 : w_prod[31:0],
                                (r_digits != 8'hff) ? r_digits + 1'b1 : r_digits,
                                r_ovf | (w_prod[35:32] != 4'd0));
                            r_n    <= r_n + 1'b1;
                            r_mode <= M_IDLE;
                        end
                    end else if (r_mode == M_IDENT) begin
                        if (r_nlen < elx_pkg::NameBits'(elx_pkg::MaxNameLen)) begin
                            r_name[r_nlen[elx_pkg::PosBits-1:0]] <= r_c;
                            r_nlen <= r_nlen + 1'b1;
                        end else begin
                            r_nlen <= elx_pkg::NameBits'(elx_pkg::MaxNameLen + 1);
                        end
                        if (r_eot) begin
                            r_start <= 1'b1;
                            r_st    <= S_ID2;
                        end
                    end else if (w_spec) begin
                        r_res[r_n[0]] <= '{token_kind: elx_pkg::KIND_SPEC, spec_code: w_code,
                            token_value: '0, digit_count: '0, error_code: elx_pkg::ERR_OK,
                            last_of_run: 1'b0};
                        r_n <= r_n + 1'b1;
                    end else if (w_dig) begin
                        r_acc    <= 32'(w_d);
                        r_digits <= 8'd1;
                        r_ovf    <= 1'b0;
                        r_mode   <= M_CONST;
                        if (r_eot) begin
                            r_res[r_n[0]] <= f_const(32'(w_d), 8'd1, 1'b0);
                            r_n    <= r_n + 1'b1;
                            r_mode <= M_IDLE;
                        end
                    end else if (w_alp) begin
                        r_name[0] <= r_c;
                        r_nlen    <= elx_pkg::NameBits'(1);
                        r_mode    <= M_IDENT;
                        if (r_eot) begin
                            r_start <= 1'b1;
                            r_st    <= S_ID2;
                        end
                    end
                end
                S_OUT0: begin
                    if (r_n == 2'd0) begin
                        r_st <= S_IN;
                    end else if (o_tok.ready) begin
                        r_st <= (r_n == 2'd2) ? S_OUT1 : S_IN;
                    end
                end
                S_OUT1: begin
                    if (o_tok.ready) r_st <= S_IN;
                end
                default: r_st <= S_IN;
            endcase
        end
    end

    always_comb begin
        o_tok.data  = (r_st == S_OUT1) ? r_res[1] : r_res[0];
        o_tok.data.last_of_run = (r_st == S_OUT1) || (r_n == 2'd1);
        o_tok.valid = (r_st == S_OUT1) || (r_st == S_OUT0 && r_n != 2'd0);
    end

    assign i_chr.ready = (r_st == S_IN);
endmodule
